// ----- hdl/audio_level_band_meter_assert.svh -----
// assertion macros shared by the level meter checker
`ifndef AUDIO_LEVEL_BAND_METER_ASSERT_SVH
`define AUDIO_LEVEL_BAND_METER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define ALB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ALB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// in the next cycle, also checked in reset cycles
`define ALB_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/alb_pkg.sv -----
// shared types, constants and helpers of the level meter
package alb_pkg;

  localparam int SQ_W      = 43;
  localparam int BSUM_W    = 29;
  localparam int BCNT_W    = 13;
  localparam int LVL_W     = 16;
  localparam int STEP_W    = 7;
  localparam int PHASE_W   = 6;
  localparam int QUO_W     = 43;

  localparam logic [15:0] BASS_LIMIT = 16'd1638;
  localparam logic [15:0] MID_LIMIT  = 16'd9830;
  localparam logic [STEP_W-1:0] STEP_MAX = 7'd64;

  localparam logic [1:0] CFG_SMOOTH    = 2'd0;
  localparam logic [1:0] CFG_SENS      = 2'd1;
  localparam logic [1:0] CFG_THRESHOLD = 2'd2;
  localparam logic [1:0] CFG_STEP      = 2'd3;

  localparam logic [1:0] BAND_BASS   = 2'd0;
  localparam logic [1:0] BAND_MID    = 2'd1;
  localparam logic [1:0] BAND_TREBLE = 2'd2;

  typedef struct packed {
    logic [15:0]        smoothing_factor;
    logic [15:0]        sensitivity;
    logic [15:0]        beat_threshold;
    logic [STEP_W-1:0]  decimation_step;
  } cfg_t;

  // packet totals handed from front to back
  typedef struct packed {
    logic [SQ_W-1:0]              sq_sum;
    logic [2:0][BSUM_W-1:0]       bsum;
    logic [2:0][BCNT_W-1:0]       bcnt;
  } pkt_t;

  function automatic logic [LVL_W-1:0] sat16(input logic [QUO_W-1:0] v);
    sat16 = (v > QUO_W'(16'hFFFF)) ? 16'hFFFF : v[LVL_W-1:0];
  endfunction

endpackage

// ----- hdl/audio_level_band_meter.sv -----
// Packet level meter: one sample item is taken per cycle whenever the
// two-entry packet queue has room. At each packet end the back sequencer
// works out the result in up to four divisions of 43 quotient bits,
// 22 square-root steps, then control and smoothing (a band without
// differences skips its division)
// while the front keeps accumulating the next packet. While both queue
// entries hold finished packets every input item is held off until the back
// takes one. Results leave through an output register and carry the four
// smoothed Q4.12 levels in tdata and the beat flag in tuser.
module audio_level_band_meter #(
  parameter int MAX_PACKET_SAMPLES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] sample
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [15:0] rms_level, [31:16] bass_level,
                                 // [47:32] mid_level, [63:48] treble_level
  output logic        m_tuser,   // [0] beat
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_PACKET_SAMPLES + 1);
  localparam int QW    = $bits(alb_pkg::pkt_t) + CNT_W;

  alb_pkg::cfg_t     cfg;
  alb_pkg::pkt_t     f_pkt, q_pkt;
  logic [CNT_W-1:0]  f_count, q_count;
  logic              push, pop, q_valid, q_full, accept;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.smoothing_factor <= 16'd52429;
      cfg.sensitivity      <= 16'd4096;
      cfg.beat_threshold   <= 16'd2048;
      cfg.decimation_step  <= 7'd10;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        alb_pkg::CFG_SMOOTH:    cfg.smoothing_factor <= cfg_wdata;
        alb_pkg::CFG_SENS:      cfg.sensitivity      <= cfg_wdata;
        alb_pkg::CFG_THRESHOLD: cfg.beat_threshold   <= cfg_wdata;
        alb_pkg::CFG_STEP:      cfg.decimation_step  <= cfg_wdata[alb_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  alb_front #(.MAX_PACKET_SAMPLES(MAX_PACKET_SAMPLES), .CNT_W(CNT_W)) u_front (
    .clk(clk), .rst(rst), .cfg(cfg), .accept(accept),
    .sample($signed(s_tdata)), .last(s_tlast),
    .push(push), .pkt(f_pkt), .count(f_count)
  );

  alb_queue #(.W(QW)) u_queue (
    .clk(clk), .rst(rst), .push(push), .wdata({f_count, f_pkt}),
    .pop(pop), .rdata({q_count, q_pkt}), .not_empty(q_valid), .full(q_full)
  );

  alb_back #(.CNT_W(CNT_W)) u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .q_valid(q_valid), .q_pkt(q_pkt),
    .q_count(q_count), .q_pop(pop), .out_valid(m_tvalid), .out_ready(m_tready),
    .out_data(m_tdata), .out_beat(m_tuser)
  );

endmodule

// ----- hdl/alb_front.sv -----
// per-sample accumulation of squares and decimated band differences
module alb_front #(
  parameter int MAX_PACKET_SAMPLES = 4096,
  parameter int CNT_W = 13
) (
  input  logic                clk,
  input  logic                rst,
  input  alb_pkg::cfg_t       cfg,
  input  logic                accept,
  input  logic signed [15:0]  sample,
  input  logic                last,
  output logic                push,
  output alb_pkg::pkt_t       pkt,
  output logic [CNT_W-1:0]    count
);

  localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(MAX_PACKET_SAMPLES);

  logic [alb_pkg::SQ_W-1:0]                 sq_sum, sq_sum_next;
  logic [CNT_W-1:0]                         n, n_next;
  logic [alb_pkg::PHASE_W-1:0]              phase, phase_next;
  logic signed [15:0]                       ref_s, ref_next;
  logic [2:0][alb_pkg::BSUM_W-1:0]          bsum, bsum_next;
  logic [2:0][alb_pkg::BCNT_W-1:0]          bcnt, bcnt_next;

  logic [alb_pkg::STEP_W-1:0] step_c;
  logic signed [31:0]         sq_full;
  logic [alb_pkg::SQ_W:0]     sq_add;
  logic signed [16:0]         diff;
  logic [15:0]                mag;
  logic [1:0]                 sel;
  logic [alb_pkg::BSUM_W:0]   bsum_add;

  // next packet totals for one sample
  always_comb begin
    step_c = cfg.decimation_step;
    if (step_c == '0) step_c = 7'd1;
    else if (step_c > alb_pkg::STEP_MAX) step_c = alb_pkg::STEP_MAX;
    sq_full  = sample * sample;
    sq_add   = {1'b0, sq_sum} + (alb_pkg::SQ_W+1)'(sq_full[30:0]);
    diff     = 17'(sample) - 17'(ref_s);
    mag      = diff[16] ? 16'(-diff) : diff[15:0];
    if (mag <= alb_pkg::BASS_LIMIT) sel = alb_pkg::BAND_BASS;
    else if (mag <= alb_pkg::MID_LIMIT) sel = alb_pkg::BAND_MID;
    else sel = alb_pkg::BAND_TREBLE;
    bsum_add = {1'b0, bsum[sel]} + (alb_pkg::BSUM_W+1)'(mag);

    sq_sum_next = sq_sum;
    n_next      = n;
    phase_next  = phase;
    ref_next    = ref_s;
    bsum_next   = bsum;
    bcnt_next   = bcnt;
    if (n < MaxCnt) begin
      sq_sum_next = sq_add[alb_pkg::SQ_W] ? '1 : sq_add[alb_pkg::SQ_W-1:0];
      n_next      = n + 1'b1;
      if (n == '0) begin
        ref_next   = sample;
        phase_next = '0;
      end else if ((7'(phase) + 7'd1) >= step_c) begin
        bsum_next[sel] = bsum_add[alb_pkg::BSUM_W] ? '1 : bsum_add[alb_pkg::BSUM_W-1:0];
        if (bcnt[sel] != '1) bcnt_next[sel] = bcnt[sel] + 1'b1;
        ref_next   = sample;
        phase_next = '0;
      end else begin
        phase_next = phase + 1'b1;
      end
    end
  end

  // state registers, cleared at reset and at packet end
  always_ff @(posedge clk) begin
    if (rst || (accept && last)) begin
      sq_sum <= '0;
      n      <= '0;
      phase  <= '0;
      ref_s  <= '0;
      bsum   <= '0;
      bcnt   <= '0;
    end else if (accept) begin
      sq_sum <= sq_sum_next;
      n      <= n_next;
      phase  <= phase_next;
      ref_s  <= ref_next;
      bsum   <= bsum_next;
      bcnt   <= bcnt_next;
    end
  end

  assign push       = accept && last;
  assign pkt.sq_sum = sq_sum_next;
  assign pkt.bsum   = bsum_next;
  assign pkt.bcnt   = bcnt_next;
  assign count      = n_next;

endmodule

// ----- hdl/alb_queue.sv -----
// two-entry queue of packet totals between front and back
module alb_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         not_empty,
  output logic         full
);

  logic [W-1:0] mem [2];
  logic         wr_ptr, rd_ptr;
  logic [1:0]   fill;

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wdata;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

  assign rdata     = mem[rd_ptr];
  assign not_empty = (fill != 2'd0);
  assign full      = (fill == 2'd2);

endmodule

// ----- hdl/alb_div.sv -----
// restoring divider, one quotient bit per cycle
module alb_div #(
  parameter int DW = 14
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       go,
  input  logic [alb_pkg::QUO_W-1:0]  dividend,
  input  logic [DW-1:0]              divisor,
  output logic                       done,
  output logic [alb_pkg::QUO_W-1:0]  quotient
);

  logic [DW-1:0] dv, rem;
  logic [5:0]    cnt;
  logic          busy;
  logic [DW:0]   trial;
  logic          ge;

  always_comb begin
    trial = {rem, quotient[alb_pkg::QUO_W-1]};
    ge    = trial >= {1'b0, dv};
  end

  // shift and subtract
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !go && (cnt == 6'(alb_pkg::QUO_W - 1));
      if (go) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == 6'(alb_pkg::QUO_W - 1)) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      quotient <= dividend;
      dv       <= divisor;
      rem      <= '0;
    end else if (busy) begin
      rem      <= ge ? DW'(trial - {1'b0, dv}) : trial[DW-1:0];
      quotient <= {quotient[alb_pkg::QUO_W-2:0], ge};
    end
  end

endmodule

// ----- hdl/alb_back.sv -----
// packet-end sequencer: mean, square root, band averages, smoothing, beat
module alb_back #(
  parameter int CNT_W = 13
) (
  input  logic                clk,
  input  logic                rst,
  input  alb_pkg::cfg_t       cfg,
  input  logic                q_valid,
  input  alb_pkg::pkt_t       q_pkt,
  input  logic [CNT_W-1:0]    q_count,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [63:0]         out_data,
  output logic                out_beat
);

  localparam int DW = (CNT_W + 1 > alb_pkg::BCNT_W) ? CNT_W + 1 : alb_pkg::BCNT_W;

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_RMS_DIV  = 4'd1;
  localparam logic [3:0] ST_SQRT     = 4'd2;
  localparam logic [3:0] ST_RMS_MUL  = 4'd3;
  localparam logic [3:0] ST_BAND_MUL = 4'd4;
  localparam logic [3:0] ST_BAND_GAIN = 4'd5;
  localparam logic [3:0] ST_BAND_DIV = 4'd6;
  localparam logic [3:0] ST_SMOOTH   = 4'd7;
  localparam logic [3:0] ST_OUT      = 4'd8;

  logic [3:0] state;

  alb_pkg::pkt_t                       pk;
  logic [alb_pkg::LVL_W-1:0]           cur [4];
  logic [alb_pkg::LVL_W-1:0]           lvl [4];
  logic [alb_pkg::LVL_W-1:0]           prev_bass;
  logic [1:0]                          band, k;
  logic [44:0]                         prod;
  logic [21:0]                         root;
  logic [23:0]                         srem;
  logic [43:0]                         sval;
  logic [4:0]                          scnt;

  logic                                div_go, div_done;
  logic [alb_pkg::QUO_W-1:0]           div_a, quo;
  logic [DW-1:0]                       div_b;
  logic                                out_load;

  // datapath helpers
  logic [23:0]         s_t, s_trial;
  logic [37:0]         rms_prod;
  logic [46:0]         gained;
  logic signed [16:0]  sdiff;
  logic signed [33:0]  sprod;
  logic signed [34:0]  sacc;
  logic [19:0]         bass10, prev13;

  alb_div #(.DW(DW)) u_div (
    .clk(clk), .rst(rst), .go(div_go), .dividend(div_a), .divisor(div_b),
    .done(div_done), .quotient(quo)
  );

  always_comb begin
    s_t      = {srem[21:0], sval[43:42]};
    s_trial  = {root, 2'b01};
    rms_prod = root * cfg.sensitivity;
    unique case (band)
      alb_pkg::BAND_BASS: gained = {2'b0, prod} + {1'b0, prod, 1'b0};
      alb_pkg::BAND_MID:  gained = {1'b0, prod, 1'b0};
      default:            gained = {2'b0, prod};
    endcase
    sdiff  = $signed({1'b0, lvl[k]}) - $signed({1'b0, cur[k]});
    sprod  = sdiff * $signed({1'b0, cfg.smoothing_factor});
    sacc   = $signed({3'b0, cur[k], 16'b0}) + $signed({sprod[33], sprod})
             + 35'sd32768;
    bass10 = {1'b0, lvl[1], 3'b0} + {3'b0, lvl[1], 1'b0};
    prev13 = {1'b0, prev_bass, 3'b0} + {2'b0, prev_bass, 2'b0} + {4'b0, prev_bass};
  end

  assign q_pop    = (state == ST_IDLE) && q_valid;
  assign out_load = (state == ST_OUT) && (!out_valid || out_ready);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      div_go    <= 1'b0;
      out_valid <= 1'b0;
      prev_bass <= '0;
      for (int i = 0; i < 4; i++) lvl[i] <= '0;
    end else begin
      div_go <= ((state == ST_IDLE) && q_valid) || (state == ST_BAND_GAIN);
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            pk     <= q_pkt;
            div_a  <= q_pkt.sq_sum;
            div_b  <= DW'(q_count) + 1'b1;
            state  <= ST_RMS_DIV;
          end
        end
        ST_RMS_DIV: begin
          if (div_done) begin
            sval  <= {1'b0, quo};
            srem  <= '0;
            root  <= '0;
            scnt  <= '0;
            state <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (s_t >= s_trial) begin
            srem <= s_t - s_trial;
            root <= {root[20:0], 1'b1};
          end else begin
            srem <= s_t;
            root <= {root[20:0], 1'b0};
          end
          sval <= {sval[41:0], 2'b00};
          scnt <= scnt + 1'b1;
          if (scnt == 5'd21) state <= ST_RMS_MUL;
        end
        ST_RMS_MUL: begin
          cur[0] <= alb_pkg::sat16(alb_pkg::QUO_W'(rms_prod[37:15]));
          band   <= alb_pkg::BAND_BASS;
          state  <= ST_BAND_MUL;
        end
        ST_BAND_MUL: begin
          if (pk.bcnt[band] == '0) begin
            cur[band + 2'd1] <= '0;
            if (band == alb_pkg::BAND_TREBLE) begin
              k     <= '0;
              state <= ST_SMOOTH;
            end else begin
              band <= band + 2'd1;
            end
          end else begin
            prod  <= pk.bsum[band] * cfg.sensitivity;
            state <= ST_BAND_GAIN;
          end
        end
        ST_BAND_GAIN: begin
          div_a  <= alb_pkg::QUO_W'(gained[46:15]);
          div_b  <= DW'(pk.bcnt[band]);
          state  <= ST_BAND_DIV;
        end
        ST_BAND_DIV: begin
          if (div_done) begin
            cur[band + 2'd1] <= alb_pkg::sat16(quo);
            if (band == alb_pkg::BAND_TREBLE) begin
              k     <= '0;
              state <= ST_SMOOTH;
            end else begin
              band  <= band + 2'd1;
              state <= ST_BAND_MUL;
            end
          end
        end
        ST_SMOOTH: begin
          lvl[k] <= sacc[31:16];
          k      <= k + 2'd1;
          if (k == 2'd3) state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) begin
            out_data  <= {lvl[3], lvl[2], lvl[1], lvl[0]};
            out_beat  <= (lvl[1] > cfg.beat_threshold) && (bass10 > prev13);
            prev_bass <= lvl[1];
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/alb_checker.sv -----
// port-level checks of the level meter and their binding
`include "audio_level_band_meter_assert.svh"

module alb_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic        m_tuser
);

  // a stalled result keeps its valid
  `ALB_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

  // a stalled result keeps its payload
  `ALB_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

  // a beat needs a nonzero bass level
  `ALB_ASSERT_IMP(a_beat_bass, m_tvalid && m_tuser, m_tdata[31:16] != 16'd0, "beat with zero bass")

  // reset leaves no result and an empty queue
  `ALB_ASSERT_ALWAYS(a_reset_clear, rst, !m_tvalid && s_tready, "state not cleared by reset")

endmodule

bind audio_level_band_meter alb_checker u_alb_checker (
  .clk(clk), .rst(rst), .s_tready(s_tready), .m_tvalid(m_tvalid),
  .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);

// ----- tb/tb.sv -----
// self-checking stream testbench for the packet level meter
module tb;

  typedef struct packed {
    logic [15:0] sample;
    logic        last;
  } smp_t;

  typedef struct packed {
    logic [15:0] rms;
    logic [15:0] bass;
    logic [15:0] mid;
    logic [15:0] treble;
    logic        beat;
  } lvl_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic        m_tuser;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;

  audio_level_band_meter dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic [15:0] k_smooth, k_sens, k_thresh;
  logic [6:0]  k_step;
  logic [63:0] sq_acc;
  int unsigned n_acc, phase;
  int          ref_smp;
  logic [63:0] bsum [3];
  int unsigned bcnt [3];
  logic [15:0] lvl [4];
  logic [15:0] prev_bass;

  smp_t pending_q[$];
  lvl_t levels_q[$];
  int   errors = 0;
  bit   calm = 0;
  logic took = 1'b0;

  function automatic logic [15:0] sat(input logic [63:0] v);
    return (v > 64'd65535) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic logic [63:0] root(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [15:0] ewma(input logic [15:0] old, input logic [15:0] cur);
    logic [63:0] a;
    a = 64'(old) * k_smooth + 64'(cur) * (64'd65536 - k_smooth) + 64'd32768;
    return sat(a >> 16);
  endfunction

  function automatic logic [15:0] band_avg(input int b, input int gain);
    if (bcnt[b] == 0) return 16'd0;
    return sat((bsum[b] * k_sens * gain) / (64'(bcnt[b]) << 15));
  endfunction

  task automatic clear_packet();
    sq_acc = 0; n_acc = 0; phase = 0; ref_smp = 0;
    for (int i = 0; i < 3; i++) begin
      bsum[i] = 0;
      bcnt[i] = 0;
    end
  endtask

  // works out the levels after one sample item, queues a result on last
  task automatic predict_levels(input smp_t it);
    int x, d, a, b, st;
    logic [63:0] sq, mean;
    lvl_t r;
    x = $signed(it.sample);
    st = (k_step == 0) ? 1 : (k_step > 64 ? 64 : k_step);
    if (n_acc < 4096) begin
      sq = 64'(x * x);
      sq_acc = (sq_acc > (64'd1 << 43) - 1 - sq) ? (64'd1 << 43) - 1 : sq_acc + sq;
      if (n_acc == 0) begin
        ref_smp = x; phase = 0;
      end else if (phase + 1 >= st) begin
        d = x - ref_smp;
        a = d < 0 ? -d : d;
        b = a <= 1638 ? 0 : (a <= 9830 ? 1 : 2);
        bsum[b] = bsum[b] + a;
        if (bsum[b] > (64'd1 << 29) - 1) bsum[b] = (64'd1 << 29) - 1;
        if (bcnt[b] < 8191) bcnt[b]++;
        ref_smp = x; phase = 0;
      end else begin
        phase++;
      end
      n_acc++;
    end
    if (!it.last) return;
    mean = sq_acc / (64'(n_acc) + 1);
    lvl[0] = ewma(lvl[0], sat((root(mean) * k_sens) >> 15));
    lvl[1] = ewma(lvl[1], band_avg(0, 3));
    lvl[2] = ewma(lvl[2], band_avg(1, 2));
    lvl[3] = ewma(lvl[3], band_avg(2, 1));
    r.beat = (lvl[1] > k_thresh) && (64'(lvl[1]) * 10 > 64'(prev_bass) * 13);
    prev_bass = lvl[1];
    r.rms = lvl[0]; r.bass = lvl[1]; r.mid = lvl[2]; r.treble = lvl[3];
    levels_q.insert(levels_q.size(), r);
    clear_packet();
  endtask

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    errors++;
  endtask

  // input handshake seen at rising edge
  always @(posedge clk) begin
    took <= !rst && s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready) begin
      predict_levels(pending_q.pop_front());
    end
  end

  // driver: holds a waiting item, changes at falling edge
  always @(negedge clk) begin
    if (!rst) begin
      if (!s_tvalid || took) begin
        if (pending_q.size() > 0 && (calm || $urandom_range(99) >= 35)) begin
          s_tvalid <= 1'b1;
          s_tdata  <= pending_q[0].sample;
          s_tlast  <= pending_q[0].last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= calm || $urandom_range(99) >= 35;
    end
  end

  // monitor: compare accepted results at rising edge
  always @(posedge clk) begin
    lvl_t w;
    if (!rst && m_tvalid && m_tready) begin
      if (levels_q.size() == 0) begin
        report("unexpected result", m_tdata[15:0], 16'd0);
      end else begin
        w = levels_q.pop_front();
        if (m_tdata[15:0] !== w.rms) report("rms", m_tdata[15:0], w.rms);
        if (m_tdata[31:16] !== w.bass) report("bass", m_tdata[31:16], w.bass);
        if (m_tdata[47:32] !== w.mid) report("mid", m_tdata[47:32], w.mid);
        if (m_tdata[63:48] !== w.treble) report("treble", m_tdata[63:48], w.treble);
        if (m_tuser !== w.beat) report("beat", 16'(m_tuser), 16'(w.beat));
      end
    end
  end

  task automatic add_item(input logic [15:0] s, input logic l);
    smp_t it;
    it.sample = s;
    it.last = l;
    pending_q.insert(pending_q.size(), it);
  endtask

  task automatic drain();
    // wait until every item is taken and every result has come back
    while (pending_q.size() > 0 || s_tvalid || levels_q.size() > 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] v);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_addr <= idx; cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      alb_pkg::CFG_SMOOTH:    k_smooth = v;
      alb_pkg::CFG_SENS:      k_sens = v;
      alb_pkg::CFG_THRESHOLD: k_thresh = v;
      default:                k_step = v[6:0];
    endcase
  endtask

  // random packet: smooth ramps and walks, noise or full-scale steps
  task automatic rand_packet(input int len);
    int v, inc, mode;
    mode = $urandom_range(3);
    v = $signed(16'($urandom));
    inc = $urandom_range(4000) - 2000;
    for (int i = 0; i < len; i++) begin
      case (mode)
        0: v = v + inc;
        1: v = $signed(16'($urandom));
        2: v = v + $urandom_range(600) - 300;
        default: v = (i % 2) ? 32767 : -32768;
      endcase
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      add_item(16'(v), i == len - 1);
    end
  endtask

  initial begin
    k_smooth = 16'd52429; k_sens = 16'd4096; k_thresh = 16'd2048; k_step = 7'd10;
    clear_packet();
    for (int i = 0; i < 4; i++) lvl[i] = 0;
    prev_bass = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, single-sample packet, band edges
    add_item(16'h7FFF, 1'b1);
    add_item(16'h8000, 1'b1);
    add_item(16'h0000, 1'b0);
    add_item(16'h0000, 1'b1);
    write_reg(alb_pkg::CFG_STEP, 16'd1);
    add_item(16'd0, 1'b0); add_item(16'd1638, 1'b0); add_item(16'd0, 1'b0);
    add_item(16'd1639, 1'b0); add_item(16'd11469, 1'b0); add_item(16'd1638, 1'b0);
    add_item(16'h8000, 1'b0); add_item(16'h7FFF, 1'b1);
    drain();
    write_reg(alb_pkg::CFG_STEP, 16'd0);
    write_reg(alb_pkg::CFG_SENS, 16'hFFFF);
    write_reg(alb_pkg::CFG_SMOOTH, 16'd0);
    write_reg(alb_pkg::CFG_THRESHOLD, 16'd0);
    add_item(16'h8000, 1'b0); add_item(16'h7FFF, 1'b0); add_item(16'h8000, 1'b1);
    add_item(16'd100, 1'b0); add_item(16'd1000, 1'b1);
    drain();
    // step above range on a packet long enough to difference
    write_reg(alb_pkg::CFG_STEP, 16'd127);
    write_reg(alb_pkg::CFG_SMOOTH, 16'hFFFF);
    for (int i = 0; i < 80; i++) add_item(16'($urandom), i == 79);
    drain();

    // random phases with several settings
    for (int ph = 0; ph < 6; ph++) begin
      calm = (ph == 2);
      write_reg(alb_pkg::CFG_SMOOTH, ph == 3 ? 16'd0 : 16'($urandom));
      write_reg(alb_pkg::CFG_SENS, ph == 4 ? 16'd0 : 16'($urandom_range(12000)));
      write_reg(alb_pkg::CFG_THRESHOLD, 16'($urandom_range(6000)));
      write_reg(alb_pkg::CFG_STEP, 16'($urandom_range(ph == 5 ? 64 : 12)));
      for (int p = 0; p < 8; p++) rand_packet($urandom_range(30) + 1);
      drain();
    end

    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
